/* rtl/assert_macros.svh */
// assertion macros used by the rtl of the barrier evaluator
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CCBE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ccbe same-cycle check failed");

// next-cycle implication
`define CCBE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ccbe next-cycle check failed");

`endif

/* rtl/ccbe_pkg.sv */
// types, register indexes and saturation helpers for the barrier evaluator
// no dependencies
package ccbe_pkg;

   typedef enum logic [2:0] {
      CSR_OBSTACLE_X,
      CSR_OBSTACLE_Y,
      CSR_OBSTACLE_VEL_X,
      CSR_OBSTACLE_VEL_Y,
      CSR_SAFE_DISTANCE,
      CSR_COS_CONE_ANGLE
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] robot_x;
      logic signed [31:0] robot_y;
      logic signed [31:0] robot_vel_x;
      logic signed [31:0] robot_vel_y;
   } req_payload_type;

   typedef struct packed {
      logic signed [47:0] barrier_value;
      logic signed [31:0] grad_x;
      logic signed [31:0] grad_y;
   } rsp_payload_type;

   // relative position and velocity carried through the root pipeline
   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
   } sq_carry_type;

   // values carried alongside the x gradient divider
   typedef struct packed {
      logic [46:0]        t16;
      logic signed [48:0] pv;
      logic [45:0]        dsq_hi;
      logic               pn_zero;
      logic signed [31:0] vx;
      logic               px_neg;
   } xdiv_carry_type;

   // values carried alongside the y gradient divider
   typedef struct packed {
      logic signed [31:0] vy;
      logic               py_neg;
   } ydiv_carry_type;

   localparam int SQ_CARRY_W  = $bits(sq_carry_type);
   localparam int DIV_CARRY_W = $bits(xdiv_carry_type);

   function automatic logic signed [31:0] sat33to32(input logic signed [32:0] x);
      logic signed [31:0] r;
      if (x[32] != x[31]) begin
         r = x[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sat36to32(input logic signed [35:0] x);
      logic signed [31:0] r;
      if (x > 36'sh0_7fff_ffff) begin
         r = 32'sh7fff_ffff;
      end else if (x < -36'sh0_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [47:0] sat50to48(input logic signed [49:0] x);
      logic signed [47:0] r;
      if (x > 50'sh0_7fff_ffff_ffff) begin
         r = 48'sh7fff_ffff_ffff;
      end else if (x < -50'sh0_8000_0000_0000) begin
         r = 48'sh8000_0000_0000;
      end else begin
         r = x[47:0];
      end
      return r;
   endfunction

   function automatic logic [31:0] mag32(input logic signed [31:0] x);
      return x[31] ? 32'(-x) : 32'(x);
   endfunction

endpackage

/* rtl/collision_cone_barrier_eval_unit.sv */
// Collision-cone barrier evaluator, top level.
// depends on ccbe_pkg, ccbe_sqrt_pipe, ccbe_div_pipe and assert_macros.svh
//
// Usage:
//  - csr channel writes the obstacle position, obstacle velocity, safe
//    distance and cone cosine by index; csr_ready is always high. Write
//    only while no request is in flight. Indexes beyond the list are dropped.
//  - req channel takes one robot sample (position, velocity) per request.
//  - rsp channel returns the barrier value and its x and y gradient.
// Pipeline: an accepted request reaches rsp through 71 register stages: 3 front
//  stages (differences, products, sums), 32 square-root stages, 1 product
//  stage, 32 divider stages, 3 back stages.
// Throughput: one request per cycle while rsp is not stalled; every stage is
//  pipelined, the root and divider units resolve one bit per stage.
// Stall: while rsp_valid is high and rsp_ready low the whole pipeline holds
//  and req_ready is low; nothing is dropped or repeated.
// Reset: synchronous; clears all valid bits and the configuration registers.
`include "assert_macros.svh"

module collision_cone_barrier_eval_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  ccbe_pkg::req_payload_type  req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output ccbe_pkg::rsp_payload_type  rsp_payload,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [2:0]                 csr_index,
   input  logic [31:0]                csr_data
);

   logic en;

   // configuration registers
   logic signed [31:0] obstacle_x_ff;
   logic signed [31:0] obstacle_y_ff;
   logic signed [31:0] obstacle_vel_x_ff;
   logic signed [31:0] obstacle_vel_y_ff;
   logic [30:0]        safe_distance_ff;
   logic signed [17:0] cos_cone_angle_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         obstacle_x_ff     <= '0;
         obstacle_y_ff     <= '0;
         obstacle_vel_x_ff <= '0;
         obstacle_vel_y_ff <= '0;
         safe_distance_ff  <= '0;
         cos_cone_angle_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            ccbe_pkg::CSR_OBSTACLE_X:     obstacle_x_ff     <= csr_data;
            ccbe_pkg::CSR_OBSTACLE_Y:     obstacle_y_ff     <= csr_data;
            ccbe_pkg::CSR_OBSTACLE_VEL_X: obstacle_vel_x_ff <= csr_data;
            ccbe_pkg::CSR_OBSTACLE_VEL_Y: obstacle_vel_y_ff <= csr_data;
            ccbe_pkg::CSR_SAFE_DISTANCE:  safe_distance_ff  <= csr_data[30:0];
            ccbe_pkg::CSR_COS_CONE_ANGLE: cos_cone_angle_ff <= csr_data[17:0];
            default: ;
         endcase
      end
   end

   logic [17:0] magc;
   logic        c_neg;
   assign c_neg = cos_cone_angle_ff[17];
   assign magc  = c_neg ? 18'(-cos_cone_angle_ff) : 18'(cos_cone_angle_ff);

   logic rsp_valid_ff;
   ccbe_pkg::rsp_payload_type rsp_payload_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // stage a: saturated differences
   logic a_valid_ff;
   ccbe_pkg::sq_carry_type a_car_ff;
   ccbe_pkg::sq_carry_type a_car_in;

   always_comb begin
      a_car_in.px = ccbe_pkg::sat33to32(33'(obstacle_x_ff) - 33'(req_payload.robot_x));
      a_car_in.py = ccbe_pkg::sat33to32(33'(obstacle_y_ff) - 33'(req_payload.robot_y));
      a_car_in.vx = ccbe_pkg::sat33to32(33'(obstacle_vel_x_ff) -
                                        33'(req_payload.robot_vel_x));
      a_car_in.vy = ccbe_pkg::sat33to32(33'(obstacle_vel_y_ff) -
                                        33'(req_payload.robot_vel_y));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_car_ff <= a_car_in;
      end
   end

   // stage b: squares and dot-product terms
   logic b_valid_ff;
   ccbe_pkg::sq_carry_type b_car_ff;
   logic [62:0]        pxx_ff;
   logic [62:0]        pyy_ff;
   logic [62:0]        vxx_ff;
   logic [62:0]        vyy_ff;
   logic signed [63:0] dota_ff;
   logic signed [63:0] dotb_ff;
   logic signed [63:0] pxx_in;
   logic signed [63:0] pyy_in;
   logic signed [63:0] vxx_in;
   logic signed [63:0] vyy_in;

   assign pxx_in = 64'(a_car_ff.px) * 64'(a_car_ff.px);
   assign pyy_in = 64'(a_car_ff.py) * 64'(a_car_ff.py);
   assign vxx_in = 64'(a_car_ff.vx) * 64'(a_car_ff.vx);
   assign vyy_in = 64'(a_car_ff.vy) * 64'(a_car_ff.vy);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_car_ff <= a_car_ff;
         pxx_ff   <= pxx_in[62:0];
         pyy_ff   <= pyy_in[62:0];
         vxx_ff   <= vxx_in[62:0];
         vyy_ff   <= vyy_in[62:0];
         dota_ff  <= 64'(a_car_ff.px) * 64'(a_car_ff.vx);
         dotb_ff  <= 64'(a_car_ff.py) * 64'(a_car_ff.vy);
      end
   end

   // stage c: sums
   logic c_valid_ff;
   ccbe_pkg::sq_carry_type c_car_ff;
   logic [63:0]        psq_ff;
   logic [63:0]        vsq_ff;
   logic signed [64:0] pvs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_car_ff <= b_car_ff;
         psq_ff   <= {1'b0, pxx_ff} + {1'b0, pyy_ff};
         vsq_ff   <= {1'b0, vxx_ff} + {1'b0, vyy_ff};
         pvs_ff   <= 65'(dota_ff) + 65'(dotb_ff);
      end
   end

   // square roots of |p|^2 and |v|^2
   logic        p_valid;
   logic        v_valid;
   logic [31:0] pn;
   logic [31:0] vn;
   logic [ccbe_pkg::SQ_CARRY_W-1:0] p_carry_bits;
   logic [64:0] pvs_bits;
   ccbe_pkg::sq_carry_type p_carry;

   ccbe_sqrt_pipe #(.PW(ccbe_pkg::SQ_CARRY_W)) u_sqrt_p (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (c_valid_ff),
      .in_radicand (psq_ff),
      .in_carry    (c_car_ff),
      .out_valid   (p_valid),
      .out_root    (pn),
      .out_carry   (p_carry_bits)
   );

   ccbe_sqrt_pipe #(.PW(65)) u_sqrt_v (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (c_valid_ff),
      .in_radicand (vsq_ff),
      .in_carry    (pvs_ff),
      .out_valid   (v_valid),
      .out_root    (vn),
      .out_carry   (pvs_bits)
   );

   assign p_carry = p_carry_bits;

   // stage d: norm products and divider operands
   logic d_valid_ff;
   ccbe_pkg::xdiv_carry_type d_x_ff;
   ccbe_pkg::ydiv_carry_type d_y_ff;
   logic [62:0] nx_ff;
   logic [62:0] ny_ff;
   logic [31:0] pn_ff;
   logic [63:0] pnvn_in;
   logic [63:0] nx_in;
   logic [63:0] ny_in;
   logic [61:0] dsq_in;

   assign pnvn_in = 64'(pn) * 64'(vn);
   assign nx_in   = 64'(ccbe_pkg::mag32(p_carry.px)) * 64'(vn);
   assign ny_in   = 64'(ccbe_pkg::mag32(p_carry.py)) * 64'(vn);
   assign dsq_in  = 62'(safe_distance_ff) * 62'(safe_distance_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (en) begin
         d_valid_ff <= p_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_x_ff.t16     <= pnvn_in[62:16];
         d_x_ff.pv      <= pvs_bits[64:16];
         d_x_ff.dsq_hi  <= dsq_in[61:16];
         d_x_ff.pn_zero <= pn == '0;
         d_x_ff.vx      <= p_carry.vx;
         d_x_ff.px_neg  <= p_carry.px[31];
         d_y_ff.vy      <= p_carry.vy;
         d_y_ff.py_neg  <= p_carry.py[31];
         nx_ff          <= nx_in[62:0];
         ny_ff          <= ny_in[62:0];
         pn_ff          <= pn;
      end
   end

   // dividers for the gradient cone term
   logic        x_valid;
   logic        y_valid;
   logic [31:0] qx;
   logic [31:0] qy;
   logic [ccbe_pkg::DIV_CARRY_W-1:0] x_carry_bits;
   logic [$bits(ccbe_pkg::ydiv_carry_type)-1:0] y_carry_bits;
   ccbe_pkg::xdiv_carry_type x_carry;
   ccbe_pkg::ydiv_carry_type y_carry;

   ccbe_div_pipe #(.PW(ccbe_pkg::DIV_CARRY_W)) u_div_x (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (d_valid_ff),
      .in_num       (nx_ff),
      .in_den       (pn_ff),
      .in_carry     (d_x_ff),
      .out_valid    (x_valid),
      .out_quotient (qx),
      .out_carry    (x_carry_bits)
   );

   ccbe_div_pipe #(.PW($bits(ccbe_pkg::ydiv_carry_type))) u_div_y (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (d_valid_ff),
      .in_num       (ny_ff),
      .in_den       (pn_ff),
      .in_carry     (d_y_ff),
      .out_valid    (y_valid),
      .out_quotient (qy),
      .out_carry    (y_carry_bits)
   );

   assign x_carry = x_carry_bits;
   assign y_carry = y_carry_bits;

   // stage e: cosine products
   logic e_valid_ff;
   ccbe_pkg::xdiv_carry_type e_x_ff;
   ccbe_pkg::ydiv_carry_type e_y_ff;
   logic [49:0] lo_ff;
   logic [32:0] hi_ff;
   logic [49:0] rx_ff;
   logic [49:0] ry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (en) begin
         e_valid_ff <= x_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_x_ff <= x_carry;
         e_y_ff <= y_carry;
         lo_ff  <= 50'(x_carry.t16[31:0]) * 50'(magc);
         hi_ff  <= 33'(x_carry.t16[46:32]) * 33'(magc);
         rx_ff  <= 50'(qx) * 50'(magc);
         ry_ff  <= 50'(qy) * 50'(magc);
      end
   end

   // stage f: signed cone terms
   logic f_valid_ff;
   logic signed [48:0] f_pv_ff;
   logic [45:0]        f_dsq_ff;
   logic               f_pnz_ff;
   logic signed [31:0] f_vx_ff;
   logic signed [31:0] f_vy_ff;
   logic signed [48:0] cone_ff;
   logic signed [34:0] mx_ff;
   logic signed [34:0] my_ff;
   logic [64:0]        cone_full;
   logic [47:0]        cone_mag;

   assign cone_full = {hi_ff, 32'b0} + 65'(lo_ff);
   assign cone_mag  = cone_full[63:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (en) begin
         f_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_pv_ff  <= e_x_ff.pv;
         f_dsq_ff <= e_x_ff.dsq_hi;
         f_pnz_ff <= e_x_ff.pn_zero;
         f_vx_ff  <= e_x_ff.vx;
         f_vy_ff  <= e_y_ff.vy;
         cone_ff  <= c_neg ? -$signed({1'b0, cone_mag}) : $signed({1'b0, cone_mag});
         mx_ff    <= (e_x_ff.px_neg ^ c_neg) ? -$signed({1'b0, rx_ff[49:16]})
                                             : $signed({1'b0, rx_ff[49:16]});
         my_ff    <= (e_y_ff.py_neg ^ c_neg) ? -$signed({1'b0, ry_ff[49:16]})
                                             : $signed({1'b0, ry_ff[49:16]});
      end
   end

   // output stage: sums and saturation
   logic signed [49:0] h_sum;
   logic signed [35:0] gx_sum;
   logic signed [35:0] gy_sum;
   ccbe_pkg::rsp_payload_type rsp_payload_in;

   assign h_sum  = 50'(f_pv_ff) + 50'(cone_ff);
   assign gx_sum = -36'(f_vx_ff) - (f_pnz_ff ? 36'sd0 : 36'(mx_ff));
   assign gy_sum = -36'(f_vy_ff) - (f_pnz_ff ? 36'sd0 : 36'(my_ff));

   always_comb begin
      rsp_payload_in.barrier_value = f_pnz_ff ? -$signed({2'b00, f_dsq_ff})
                                              : ccbe_pkg::sat50to48(h_sum);
      rsp_payload_in.grad_x        = ccbe_pkg::sat36to32(gx_sum);
      rsp_payload_in.grad_y        = ccbe_pkg::sat36to32(gy_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // both root units and both dividers march in lockstep
   `CCBE_ASSERT_NOW(a_sqrt_lockstep, clock, reset, 1'b1, p_valid == v_valid)
   `CCBE_ASSERT_NOW(a_div_lockstep, clock, reset, 1'b1, x_valid == y_valid)
   // a zero root of |p|^2 only comes from a zero relative position
   `CCBE_ASSERT_NOW(a_zero_root, clock, reset, p_valid && pn == '0,
                    p_carry.px == '0 && p_carry.py == '0)
   // a stalled request keeps its place and its cone term
   `CCBE_ASSERT_NEXT(a_stall_hold, clock, reset, f_valid_ff && !en,
                     f_valid_ff && $stable(cone_ff))

endmodule

/* rtl/ccbe_sqrt_pipe.sv */
// pipelined floor square root, one result bit per stage, with side payload
// depends on ccbe_pkg
module ccbe_sqrt_pipe #(
   parameter int PW = ccbe_pkg::SQ_CARRY_W
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [63:0]   in_radicand,
   input  logic [PW-1:0] in_carry,
   output logic          out_valid,
   output logic [31:0]   out_root,
   output logic [PW-1:0] out_carry
);

   localparam int STEPS = 32;

   logic          valid_ff [STEPS];
   logic [63:0]   rad_ff   [STEPS];
   logic [33:0]   rem_ff   [STEPS];
   logic [31:0]   root_ff  [STEPS];
   logic [PW-1:0] carry_ff [STEPS];

   for (genvar g = 0; g < STEPS; g++) begin : g_step
      logic          v_src;
      logic [63:0]   rad_src;
      logic [33:0]   rem_src;
      logic [31:0]   root_src;
      logic [PW-1:0] carry_src;
      logic [35:0]   rem_sh;
      logic [35:0]   trial;
      logic          fits;
      logic [33:0]   rem_in;
      logic [31:0]   root_in;

      if (g == 0) begin : g_head
         assign v_src     = in_valid;
         assign rad_src   = in_radicand;
         assign rem_src   = '0;
         assign root_src  = '0;
         assign carry_src = in_carry;
      end else begin : g_body
         assign v_src     = valid_ff[g-1];
         assign rad_src   = rad_ff[g-1];
         assign rem_src   = rem_ff[g-1];
         assign root_src  = root_ff[g-1];
         assign carry_src = carry_ff[g-1];
      end

      assign rem_sh  = {rem_src, rad_src[63:62]};
      assign trial   = {2'b00, root_src, 2'b01};
      assign fits    = rem_sh >= trial;
      assign rem_in  = fits ? 34'(rem_sh - trial) : rem_sh[33:0];
      assign root_in = {root_src[30:0], fits};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (en) begin
            valid_ff[g] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[g]   <= {rad_src[61:0], 2'b00};
            rem_ff[g]   <= rem_in;
            root_ff[g]  <= root_in;
            carry_ff[g] <= carry_src;
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_root  = root_ff[STEPS-1];
   assign out_carry = carry_ff[STEPS-1];

endmodule

/* rtl/ccbe_div_pipe.sv */
// pipelined restoring divider, 63-bit dividend by 32-bit divisor, 32-bit quotient
// one quotient bit per stage; depends on ccbe_pkg
module ccbe_div_pipe #(
   parameter int PW = ccbe_pkg::DIV_CARRY_W
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [62:0]   in_num,
   input  logic [31:0]   in_den,
   input  logic [PW-1:0] in_carry,
   output logic          out_valid,
   output logic [31:0]   out_quotient,
   output logic [PW-1:0] out_carry
);

   localparam int STEPS = 32;

   logic          valid_ff [STEPS];
   logic [31:0]   rem_ff   [STEPS];
   logic [31:0]   low_ff   [STEPS];
   logic [31:0]   quo_ff   [STEPS];
   logic [31:0]   den_ff   [STEPS];
   logic [PW-1:0] carry_ff [STEPS];

   for (genvar g = 0; g < STEPS; g++) begin : g_step
      logic          v_src;
      logic [31:0]   rem_src;
      logic [31:0]   low_src;
      logic [31:0]   quo_src;
      logic [31:0]   den_src;
      logic [PW-1:0] carry_src;
      logic [32:0]   sh;
      logic          fits;
      logic [31:0]   rem_in;

      if (g == 0) begin : g_head
         assign v_src     = in_valid;
         assign rem_src   = {1'b0, in_num[62:32]};
         assign low_src   = in_num[31:0];
         assign quo_src   = '0;
         assign den_src   = in_den;
         assign carry_src = in_carry;
      end else begin : g_body
         assign v_src     = valid_ff[g-1];
         assign rem_src   = rem_ff[g-1];
         assign low_src   = low_ff[g-1];
         assign quo_src   = quo_ff[g-1];
         assign den_src   = den_ff[g-1];
         assign carry_src = carry_ff[g-1];
      end

      assign sh     = {rem_src, low_src[31]};
      assign fits   = sh >= {1'b0, den_src};
      assign rem_in = fits ? 32'(sh - {1'b0, den_src}) : sh[31:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (en) begin
            valid_ff[g] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g]   <= rem_in;
            low_ff[g]   <= {low_src[30:0], 1'b0};
            quo_ff[g]   <= {quo_src[30:0], fits};
            den_ff[g]   <= den_src;
            carry_ff[g] <= carry_src;
         end
      end
   end

   assign out_valid    = valid_ff[STEPS-1];
   assign out_quotient = quo_ff[STEPS-1];
   assign out_carry    = carry_ff[STEPS-1];

endmodule

/* tb/tb_collision_cone_barrier_eval_unit.sv */
// testbench for the collision-cone barrier evaluator: random and directed robot samples,
// a bit-exact predictor of barrier value and gradient, and in-order result checking
// depends on ccbe_pkg and collision_cone_barrier_eval_unit
module tb_collision_cone_barrier_eval_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PIPE_LATENCY = 71;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready, csr_valid, csr_ready;
   ccbe_pkg::req_payload_type req_payload;
   ccbe_pkg::rsp_payload_type rsp_payload;
   logic [2:0] csr_index;
   logic [31:0] csr_data;

   collision_cone_barrier_eval_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // obstacle state as seen by the predictor
   logic signed [31:0] obs_x, obs_y, obs_vx, obs_vy;
   logic [30:0] safe_dist;
   logic signed [17:0] cone_cos;

   ccbe_pkg::req_payload_type sample_queue[$];
   ccbe_pkg::rsp_payload_type barrier_queue[$];
   int mismatch_count = 0;
   int req_gap = 0, rsp_gap = 0;
   logic req_accepted = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint sat_to(longint x, int w);
      longint hi, lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (x > hi) return hi;
      if (x < lo) return lo;
      return x;
   endfunction

   function automatic longint unsigned isqrt(longint unsigned x);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'h4000_0000_0000_0000;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint unsigned absval(longint x);
      return x < 0 ? longint'(-x) : x;
   endfunction

   function automatic longint gradient_axis(longint pc, longint vc, longint unsigned pn,
                                            longint unsigned vn, longint c);
      longint g, m;
      longint unsigned r;
      g = -vc;
      if (pn != 0) begin
         r = (absval(pc) * vn) / pn;
         m = longint'((r * absval(c)) >> 16);
         g = ((pc < 0) != (c < 0)) ? g + m : g - m;
      end
      return sat_to(g, 32);
   endfunction

   function automatic longint floor_q16(longint x);
      if (x >= 0) return x / 65536;
      return -((-x + 65535) / 65536);
   endfunction

   function automatic ccbe_pkg::rsp_payload_type predict_barrier(
         ccbe_pkg::req_payload_type s);
      ccbe_pkg::rsp_payload_type r;
      longint px, py, vx, vy, h, a, b, qa, qb, m;
      longint unsigned pn, vn, t16, ds;
      longint c;
      px = sat_to(longint'(obs_x) - longint'(s.robot_x), 32);
      py = sat_to(longint'(obs_y) - longint'(s.robot_y), 32);
      vx = sat_to(longint'(obs_vx) - longint'(s.robot_vel_x), 32);
      vy = sat_to(longint'(obs_vy) - longint'(s.robot_vel_y), 32);
      c = longint'(cone_cos);
      ds = longint'({1'b0, safe_dist});
      pn = isqrt(absval(px) * absval(px) + absval(py) * absval(py));
      vn = isqrt(absval(vx) * absval(vx) + absval(vy) * absval(vy));
      if (pn == 0) begin
         h = -longint'((ds * ds) >> 16);
      end else begin
         a = px * vx;
         b = py * vy;
         qa = floor_q16(a);
         qb = floor_q16(b);
         h = qa + qb + (((a - qa * 65536) + (b - qb * 65536)) / 65536);
         t16 = (pn * vn) >> 16;
         m = longint'((t16 * absval(c)) >> 16);
         h = sat_to(c < 0 ? h - m : h + m, 48);
      end
      r.barrier_value = h[47:0];
      r.grad_x = 32'(gradient_axis(px, vx, pn, vn, c));
      r.grad_y = 32'(gradient_axis(py, vy, pn, vn, c));
      return r;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", field, got, want);
      mismatch_count++;
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_accepted) begin
      end else begin
         if (req_accepted) req_gap = $urandom_range(0, 3);
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (sample_queue.size() > 0) begin
            req_payload <= sample_queue.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         rsp_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 0;
      end
   end

   // monitor
   always @(posedge clock) begin
      ccbe_pkg::rsp_payload_type want;
      req_accepted = !reset && req_valid && req_ready;
      if (req_accepted) barrier_queue.push_back(predict_barrier(req_payload));
      if (!reset && rsp_valid && rsp_ready) begin
         if (barrier_queue.size() == 0) begin
            report_mismatch("unexpected", 0, 0);
         end else begin
            want = barrier_queue.pop_front();
            if (rsp_payload.barrier_value !== want.barrier_value)
               report_mismatch("barrier_value", rsp_payload.barrier_value,
                               want.barrier_value);
            if (rsp_payload.grad_x !== want.grad_x)
               report_mismatch("grad_x", rsp_payload.grad_x, want.grad_x);
            if (rsp_payload.grad_y !== want.grad_y)
               report_mismatch("grad_y", rsp_payload.grad_y, want.grad_y);
         end
      end
   end

   task automatic write_reg(ccbe_pkg::csr_index_type idx, logic [31:0] value);
      @(negedge clock);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         ccbe_pkg::CSR_OBSTACLE_X: obs_x = value;
         ccbe_pkg::CSR_OBSTACLE_Y: obs_y = value;
         ccbe_pkg::CSR_OBSTACLE_VEL_X: obs_vx = value;
         ccbe_pkg::CSR_OBSTACLE_VEL_Y: obs_vy = value;
         ccbe_pkg::CSR_SAFE_DISTANCE: safe_dist = value[30:0];
         ccbe_pkg::CSR_COS_CONE_ANGLE: cone_cos = value[17:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain_pipeline();
      while (sample_queue.size() > 0 || req_valid || barrier_queue.size() > 0)
         @(posedge clock);
      repeat (PIPE_LATENCY + 5) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 5))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3: return $urandom_range(0, 65536 * 8) - 65536 * 4;
         default: return $urandom;
      endcase
   endfunction

   function automatic ccbe_pkg::req_payload_type random_sample();
      ccbe_pkg::req_payload_type s;
      s.robot_x = ($urandom_range(0, 9) == 0) ? obs_x : pick_word();
      s.robot_y = ($urandom_range(0, 9) == 0) ? obs_y : pick_word();
      s.robot_vel_x = pick_word();
      s.robot_vel_y = pick_word();
      return s;
   endfunction

   function automatic void queue_sample(logic [31:0] x, logic [31:0] y,
                                        logic [31:0] vx, logic [31:0] vy);
      ccbe_pkg::req_payload_type s;
      s.robot_x = x;
      s.robot_y = y;
      s.robot_vel_x = vx;
      s.robot_vel_y = vy;
      sample_queue.push_back(s);
   endfunction

   function automatic logic [31:0] random_cos();
      case ($urandom_range(0, 4))
         0: return 32'(18'sh10000);
         1: return 32'(-18'sh10000);
         2: return 32'h1ffff;
         3: return 32'h20000;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      rsp_ready = 1'b0;
      req_payload = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      obs_x = 0; obs_y = 0; obs_vx = 0; obs_vy = 0;
      safe_dist = 0; cone_cos = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // on-obstacle and extremes at reset settings
      queue_sample(0, 0, 0, 0);
      queue_sample(0, 0, 32'h7fff_ffff, 32'h8000_0000);
      drain_pipeline();
      write_reg(ccbe_pkg::CSR_OBSTACLE_X, 32'h0001_0000);
      write_reg(ccbe_pkg::CSR_OBSTACLE_Y, 32'hffff_0000);
      write_reg(ccbe_pkg::CSR_OBSTACLE_VEL_X, 32'h7fff_ffff);
      write_reg(ccbe_pkg::CSR_OBSTACLE_VEL_Y, 32'h8000_0000);
      write_reg(ccbe_pkg::CSR_SAFE_DISTANCE, 32'h7fff_ffff);
      write_reg(ccbe_pkg::CSR_COS_CONE_ANGLE, 32'(18'sh10000));
      queue_sample(32'h0001_0000, 32'hffff_0000, 0, 0);
      queue_sample(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      queue_sample(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
      queue_sample(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      queue_sample(0, 0, 32'h0000_0001, 32'h0001_0000);
      drain_pipeline();
      write_reg(ccbe_pkg::CSR_COS_CONE_ANGLE, 32'h20000);
      write_reg(ccbe_pkg::CSR_OBSTACLE_X, 32'h8000_0000);
      write_reg(ccbe_pkg::CSR_OBSTACLE_Y, 32'h7fff_ffff);
      write_reg(ccbe_pkg::csr_index_type'(3'd7), 32'hdead_beef);
      queue_sample(32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678, 32'h8765_4321);
      queue_sample(32'h8000_0000, 32'h7fff_ffff, 32'h1234_5678, 32'h8765_4321);
      queue_sample(32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555);

      for (int phase = 0; phase < 10; phase++) begin
         drain_pipeline();
         write_reg(ccbe_pkg::CSR_OBSTACLE_X, pick_word());
         write_reg(ccbe_pkg::CSR_OBSTACLE_Y, pick_word());
         write_reg(ccbe_pkg::CSR_OBSTACLE_VEL_X, pick_word());
         write_reg(ccbe_pkg::CSR_OBSTACLE_VEL_Y, pick_word());
         write_reg(ccbe_pkg::CSR_SAFE_DISTANCE, phase == 0 ? 32'h0 : pick_word());
         write_reg(ccbe_pkg::CSR_COS_CONE_ANGLE, random_cos());
         for (int k = 0; k < 95; k++) sample_queue.push_back(random_sample());
      end
      drain_pipeline();
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("== FAIL ==");
      $finish;
   end
endmodule
